// ===== sv/cfba_pkg.sv =====
package cfba_pkg;

    localparam int WORD_W         = 32;
    localparam int FREE_SLOTS_DEF = 32;
    localparam logic [WORD_W-1:0] VOLUME_RESET = '1;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_REFILL = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_ACK   = 2'd0,
        KIND_GRANT = 2'd1,
        KIND_SPILL = 2'd2,
        KIND_FETCH = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_NUM  = 2'd1,
        STAT_NO_SPACE = 2'd2,
        STAT_BUSY     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_FETCH,
        ST_SPILL
    } t_state;

    typedef struct packed {
        t_action           action;
        logic [WORD_W-1:0] block_number;
        logic [WORD_W-1:0] refill_value;
    } t_req;

    typedef struct packed {
        t_kind             kind;
        t_status           status;
        logic [WORD_W-1:0] value;
        logic [WORD_W-1:0] target_block;
        logic              last;
    } t_res;

    function automatic t_res mk_res(t_kind kind, t_status status, logic [WORD_W-1:0] value,
                                    logic [WORD_W-1:0] target, logic last);
        t_res r;
        r.kind         = kind;
        r.status       = status;
        r.value        = value;
        r.target_block = target;
        r.last         = last;
        return r;
    endfunction

endpackage

// ===== sv/cfba_stack_mem.sv =====
module cfba_stack_mem
    import cfba_pkg::*;
#(
    parameter int DEPTH = FREE_SLOTS_DEF,
    parameter int AW    = $clog2(FREE_SLOTS_DEF)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [WORD_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [AW-1:0]     i_raddr,
    output logic [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/chained_free_block_allocator.sv =====
// channel   | direction | handshake                     | payload
// ----------+-----------+-------------------------------+-------------------------
// request   | in        | i_start high while o_busy low | i_req   (t_req)
// result    | out       | o_valid strobe, one cycle     | o_res   (t_res)
// config    | in        | i_cfg_we, no wait             | i_cfg_data (volume_blocks)
//
// free, refill and rejected requests are acknowledged the next cycle
// an allocate waits in ST_POP for the registered stack read; a chain pop adds ST_FETCH
// a spill sends the count word, then one stack word read from the memory port per cycle
// reset (synchronous, active low) empties the stack and ends any load; no clearing pass
// the result side cannot stall; each result is valid for exactly one cycle
module chained_free_block_allocator
    import cfba_pkg::*;
#(
    parameter int FREE_SLOTS = FREE_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_start,
    output logic              o_busy,
    input  t_req              i_req,
    // result channel
    output logic              o_valid,
    output t_res              o_res,
    // configuration
    input  logic              i_cfg_we,
    input  logic [WORD_W-1:0] i_cfg_data
);

    // count holds 0..FREE_SLOTS, slot address holds 0..FREE_SLOTS-1
    localparam int CW = $clog2(FREE_SLOTS + 1);
    localparam int AW = $clog2(FREE_SLOTS);
    localparam logic [CW-1:0]     SLOTS_C   = CW'(FREE_SLOTS);
    localparam logic [AW-1:0]     LAST_SLOT = AW'(FREE_SLOTS - 1);
    localparam logic [WORD_W-1:0] SLOTS_W   = WORD_W'(FREE_SLOTS);

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic              r_loading, n_loading;
    logic [CW-1:0]     r_load_idx, n_load_idx;   // 0: count word awaited, else 1-based slot
    logic [WORD_W-1:0] r_volume;
    logic [WORD_W-1:0] r_bn, n_bn;               // spill target or chain block
    logic [AW-1:0]     r_idx, n_idx;             // spill read pointer
    logic              r_valid, n_valid;
    t_res              r_res, n_res;

    // stack memory port signals
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [WORD_W-1:0] mem_rdata;

    logic              accept;
    logic [CW-1:0]     count_dec;
    logic [CW-1:0]     load_dec;

    // a write lands at the edge of the cycle that issues it and every read is
    // issued on a later edge, so no forwarding path is needed
    cfba_stack_mem #(
        .DEPTH (FREE_SLOTS),
        .AW    (AW)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign accept    = i_start && (r_state == ST_IDLE);
    assign count_dec = r_count - CW'(1);
    assign load_dec  = r_load_idx - CW'(1);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_loading  = r_loading;
        n_load_idx = r_load_idx;
        n_bn       = r_bn;
        n_idx      = r_idx;
        n_valid    = 1'b0;
        n_res      = mk_res(KIND_ACK, STAT_OK, '0, '0, 1'b1);
        mem_we     = 1'b0;
        mem_waddr  = r_count[AW-1:0];
        mem_wdata  = i_req.block_number;
        mem_re     = 1'b0;
        mem_raddr  = count_dec[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_req.action)
                        ACT_ALLOC: begin
                            n_valid = 1'b1;
                            if (r_loading) begin
                                n_res = mk_res(KIND_ACK, STAT_BUSY, '0, '0, 1'b1);
                            end else if (r_count == '0) begin
                                n_res = mk_res(KIND_ACK, STAT_NO_SPACE, '0, '0, 1'b1);
                            end else begin
                                // pop: result decided once the top word is read
                                n_valid = 1'b0;
                                n_count = count_dec;
                                mem_re  = 1'b1;
                                n_state = ST_POP;
                            end
                        end
                        ACT_FREE: begin
                            n_valid = 1'b1;
                            if (r_loading) begin
                                n_res = mk_res(KIND_ACK, STAT_BUSY, '0, '0, 1'b1);
                            end else if (i_req.block_number == '0 ||
                                         i_req.block_number >= r_volume) begin
                                n_res = mk_res(KIND_ACK, STAT_BAD_NUM, '0, '0, 1'b1);
                            end else if (r_count >= SLOTS_C) begin
                                // full stack: count word now, entries stream from slot 0
                                n_res     = mk_res(KIND_SPILL, STAT_OK, SLOTS_W,
                                                   i_req.block_number, 1'b0);
                                n_bn      = i_req.block_number;
                                n_idx     = '0;
                                mem_re    = 1'b1;
                                mem_raddr = '0;
                                n_state   = ST_SPILL;
                            end else begin
                                mem_we  = 1'b1;
                                n_count = r_count + CW'(1);
                            end
                        end
                        ACT_REFILL: begin
                            n_valid = 1'b1;
                            if (!r_loading || r_load_idx == '0) begin
                                // count word, saturated to the stack size
                                if (i_req.refill_value > SLOTS_W) begin
                                    n_count = SLOTS_C;
                                    n_res   = mk_res(KIND_ACK, STAT_BAD_NUM, '0, '0, 1'b1);
                                end else begin
                                    n_count = i_req.refill_value[CW-1:0];
                                end
                                n_loading  = (n_count != '0);
                                n_load_idx = (n_count != '0) ? CW'(1) : '0;
                            end else begin
                                // entry word fills the next slot
                                mem_we    = 1'b1;
                                mem_waddr = load_dec[AW-1:0];
                                mem_wdata = i_req.refill_value;
                                if (r_load_idx >= r_count) begin
                                    n_loading  = 1'b0;
                                    n_load_idx = '0;
                                end else begin
                                    n_load_idx = r_load_idx + CW'(1);
                                end
                            end
                        end
                        ACT_NOP: begin
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_valid = 1'b1;
                n_state = ST_IDLE;
                if (mem_rdata == '0) begin
                    n_res = mk_res(KIND_ACK, STAT_NO_SPACE, '0, '0, 1'b1);
                end else if (r_count == '0) begin
                    // last entry is a chain block: grant it, then ask for its contents
                    n_res      = mk_res(KIND_GRANT, STAT_OK, mem_rdata, '0, 1'b0);
                    n_bn       = mem_rdata;
                    n_loading  = 1'b1;
                    n_load_idx = '0;
                    n_state    = ST_FETCH;
                end else begin
                    n_res = mk_res(KIND_GRANT, STAT_OK, mem_rdata, '0, 1'b1);
                end
            end
            ST_FETCH: begin
                n_valid = 1'b1;
                n_res   = mk_res(KIND_FETCH, STAT_OK, '0, r_bn, 1'b1);
                n_state = ST_IDLE;
            end
            ST_SPILL: begin
                n_valid = 1'b1;
                if (r_idx == LAST_SLOT) begin
                    // stack now holds only the freed block
                    n_res     = mk_res(KIND_SPILL, STAT_OK, mem_rdata, r_bn, 1'b1);
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = r_bn;
                    n_count   = CW'(1);
                    n_state   = ST_IDLE;
                end else begin
                    n_res     = mk_res(KIND_SPILL, STAT_OK, mem_rdata, r_bn, 1'b0);
                    mem_re    = 1'b1;
                    mem_raddr = r_idx + AW'(1);
                    n_idx     = r_idx + AW'(1);
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_count    <= '0;
            r_loading  <= 1'b0;
            r_load_idx <= '0;
            r_valid    <= 1'b0;
            r_volume   <= VOLUME_RESET;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_loading  <= n_loading;
            r_load_idx <= n_load_idx;
            r_valid    <= n_valid;
            if (i_cfg_we) begin
                r_volume <= i_cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_bn  <= n_bn;
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // stack count never passes the number of slots
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= SLOTS_C)
        else $error("stack count above slot count");

    // an entry load never points past the announced count
    a_load_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_loading && r_load_idx != '0) |-> (r_load_idx <= r_count))
        else $error("load index past stack count");

    // a grant that is not last is always followed by the fetch request
    a_fetch_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_res.kind == KIND_GRANT && !o_res.last) |=>
        (o_valid && o_res.kind == KIND_FETCH && o_res.last))
        else $error("chain grant without fetch request");

    // every spill cycle delivers a spill word the next cycle
    a_spill_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SPILL) |=> (o_valid && o_res.kind == KIND_SPILL))
        else $error("spill stream broken");

endmodule

// ===== test/testbench.sv =====
module testbench;
    import cfba_pkg::*;

    localparam int SLOTS = FREE_SLOTS_DEF;

    // one line of the directed stimulus table
    typedef struct packed {
        t_action     act;
        logic [31:0] bn;
        logic [31:0] rv;
        int          reps;     // repeat the line this many times
        int          stride;   // added to both words on each repeat
        bit          typed;    // want holds the single result
        t_res        want;
    } t_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_start    = 1'b0;
    t_req        i_req      = '0;
    logic        i_cfg_we   = 1'b0;
    logic [31:0] i_cfg_data = '0;
    logic        o_busy;
    logic        o_valid;
    t_res        o_res;

    // shadow copy of the allocator state
    logic [31:0] cached_blk [SLOTS];
    logic [5:0]  cached_n;
    bit          filling;
    logic [5:0]  next_slot;
    logic [31:0] vol_blocks;

    t_res step_res [$];   // results caused by the latest request
    t_res owed_res [$];   // results still to come, oldest first
    t_row plan [$];
    int   mismatches = 0;
    int   burst_left = 0;
    bit   start_on   = 1'b0;

    chained_free_block_allocator #(
        .FREE_SLOTS (SLOTS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .o_res      (o_res),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // generous cap on the whole run
    initial begin
        #4000000;
        $display("** chained_free_block_allocator: FAILED **");
        $finish;
    end

    function automatic t_res outcome(t_kind k, t_status s, logic [31:0] v, logic [31:0] t,
                                     logic l);
        t_res r;
        r.kind         = k;
        r.status       = s;
        r.value        = v;
        r.target_block = t;
        r.last         = l;
        return r;
    endfunction

    // advance the shadow state by one request and list what it answers
    function automatic void apply_request(t_req r);
        logic [31:0] blk;
        logic [31:0] cnt;
        t_status     st;
        step_res.delete();
        case (r.action)
            ACT_ALLOC: begin
                if (filling) begin
                    step_res.push_back(outcome(KIND_ACK, STAT_BUSY, '0, '0, 1'b1));
                end else if (cached_n == 0 || cached_n > SLOTS) begin
                    // underflow
                    step_res.push_back(outcome(KIND_ACK, STAT_NO_SPACE, '0, '0, 1'b1));
                end else begin
                    cached_n = cached_n - 1'b1;
                    blk      = cached_blk[cached_n];
                    if (blk == 0) begin
                        // zero entry popped, the pop still stands
                        step_res.push_back(outcome(KIND_ACK, STAT_NO_SPACE, '0, '0, 1'b1));
                    end else if (cached_n == 0) begin
                        // chain block: grant it, then ask for its contents
                        step_res.push_back(outcome(KIND_GRANT, STAT_OK, blk, '0, 1'b0));
                        step_res.push_back(outcome(KIND_FETCH, STAT_OK, '0, blk, 1'b1));
                        filling   = 1'b1;
                        next_slot = '0;
                    end else begin
                        step_res.push_back(outcome(KIND_GRANT, STAT_OK, blk, '0, 1'b1));
                    end
                end
            end
            ACT_FREE: begin
                if (filling) begin
                    step_res.push_back(outcome(KIND_ACK, STAT_BUSY, '0, '0, 1'b1));
                end else if (r.block_number == 0 || r.block_number >= vol_blocks) begin
                    step_res.push_back(outcome(KIND_ACK, STAT_BAD_NUM, '0, '0, 1'b1));
                end else if (cached_n >= SLOTS) begin
                    // full stack goes out into the freed block
                    step_res.push_back(outcome(KIND_SPILL, STAT_OK, SLOTS, r.block_number,
                                               1'b0));
                    for (int i = 0; i < SLOTS; i++)
                        step_res.push_back(outcome(KIND_SPILL, STAT_OK, cached_blk[i],
                                                   r.block_number, i == SLOTS - 1));
                    cached_blk[0] = r.block_number;
                    cached_n      = 6'd1;
                end else begin
                    cached_blk[cached_n] = r.block_number;
                    cached_n             = cached_n + 1'b1;
                    step_res.push_back(outcome(KIND_ACK, STAT_OK, '0, '0, 1'b1));
                end
            end
            ACT_REFILL: begin
                if (!filling || next_slot == 0) begin
                    // count word, saturated to the stack size
                    cnt = r.refill_value;
                    st  = STAT_OK;
                    if (cnt > SLOTS) begin
                        cnt = SLOTS;
                        st  = STAT_BAD_NUM;
                    end
                    cached_n  = cnt[5:0];
                    filling   = cnt != 0;
                    next_slot = (cnt != 0) ? 6'd1 : 6'd0;
                    step_res.push_back(outcome(KIND_ACK, st, '0, '0, 1'b1));
                end else begin
                    if (next_slot >= 1 && next_slot <= SLOTS)
                        cached_blk[next_slot - 1] = r.refill_value;
                    if (next_slot >= cached_n) begin
                        filling   = 1'b0;
                        next_slot = '0;
                    end else begin
                        next_slot = next_slot + 1'b1;
                    end
                    step_res.push_back(outcome(KIND_ACK, STAT_OK, '0, '0, 1'b1));
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected %0h, got %0h", name, want, got);
        end
    endfunction

    // result checker; results cannot be held off, so every strobe is taken
    always @(posedge i_clk) begin
        t_res e;
        if (i_rst_n && o_valid === 1'b1) begin
            if (owed_res.size() == 0) begin
                mismatches++;
                $error("unexpected result: kind %0d value %0h", o_res.kind, o_res.value);
            end else begin
                e = owed_res.pop_front();
                check_field("kind", e.kind, o_res.kind);
                check_field("status", e.status, o_res.status);
                check_field("value", e.value, o_res.value);
                check_field("target_block", e.target_block, o_res.target_block);
                check_field("last", e.last, o_res.last);
            end
        end
    end

    task automatic row(t_action a, logic [31:0] bn, logic [31:0] rv, int reps, int stride,
                       bit typed, t_res want);
        t_row w;
        w.act    = a;
        w.bn     = bn;
        w.rv     = rv;
        w.reps   = reps;
        w.stride = stride;
        w.typed  = typed;
        w.want   = want;
        plan.push_back(w);
    endtask

    // hold the request until it is taken, then log what it owes
    task automatic issue(t_req r, bit typed, t_res want);
        i_req   <= r;
        i_start <= 1'b1;
        start_on = 1'b1;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        apply_request(r);
        if (typed)
            owed_res.push_back(want);
        else
            foreach (step_res[i]) owed_res.push_back(step_res[i]);
    endtask

    // sender bursts with random gaps, some long, some none
    task automatic pace();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 25) : $urandom_range(0, 4);
            if (gap > 0) begin
                i_start <= 1'b0;
                start_on = 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 15);
        end
    endtask

    // drain all owed results, then let a result-less request settle
    task automatic settle();
        if (start_on) begin
            i_start <= 1'b0;
            start_on = 1'b0;
        end
        while (owed_res.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_volume(logic [31:0] v);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        vol_blocks  = v;
    endtask

    function automatic logic [31:0] pick_block();
        int p;
        p = $urandom_range(0, 19);
        if (p == 0) return '0;
        if (p == 1) return vol_blocks;
        if (p == 2 || vol_blocks <= 1) return $urandom;
        return $urandom_range(1, vol_blocks - 1);
    endfunction

    // mostly well-formed traffic that follows the load protocol, some noise
    function automatic t_req random_req(int mode);
        t_req r;
        int   p;
        p              = $urandom_range(0, 99);
        r.action       = ACT_ALLOC;
        r.block_number = $urandom;
        r.refill_value = $urandom;
        if (p < 8) begin
            r.action = t_action'($urandom_range(0, 3));
        end else if (filling) begin
            if (p < 14) begin
                // rejected while loading
                r.action = ($urandom_range(0, 1) != 0) ? ACT_ALLOC : ACT_FREE;
            end else begin
                r.action = ACT_REFILL;
                if (next_slot == 0)
                    r.refill_value = (p < 20) ? $urandom : $urandom_range(0, SLOTS);
                else if (p < 24)
                    r.refill_value = '0;
                else
                    r.refill_value = pick_block();
            end
        end else if (p < 12) begin
            // refill word while idle is a count word; a nonzero count starts a load
            r.action       = ACT_REFILL;
            r.refill_value = $urandom_range(0, SLOTS + 2);
        end else begin
            case (mode)
                0:       r.action = (p < 84) ? ACT_FREE : ACT_ALLOC;   // fill toward a spill
                1:       r.action = (p < 84) ? ACT_ALLOC : ACT_FREE;   // drain toward a chain pop
                default: r.action = (p < 56) ? ACT_FREE : ACT_ALLOC;
            endcase
            r.block_number = pick_block();
        end
        return r;
    endfunction

    initial begin
        t_req        r;
        t_row        w;
        int          mode;
        logic [31:0] vols [4];

        // directed table: typed results only where they are obvious
        row(ACT_ALLOC,  32'h0,          32'h0, 1, 0, 1,
            outcome(KIND_ACK, STAT_NO_SPACE, '0, '0, 1'b1));    // empty after reset
        row(ACT_FREE,   32'h0,          32'h0, 1, 0, 1,
            outcome(KIND_ACK, STAT_BAD_NUM, '0, '0, 1'b1));     // block zero
        row(ACT_FREE,   32'hFFFF_FFFF,  32'h0, 1, 0, 1,
            outcome(KIND_ACK, STAT_BAD_NUM, '0, '0, 1'b1));     // at volume size
        row(ACT_FREE,   32'hFFFF_FFFE,  32'h0, 1, 0, 1,
            outcome(KIND_ACK, STAT_OK, '0, '0, 1'b1));          // highest legal block
        row(ACT_ALLOC,  32'h0,          32'h0, 1, 0, 0, '0);    // chain pop
        row(ACT_ALLOC,  32'h0,          32'h0, 1, 0, 1,
            outcome(KIND_ACK, STAT_BUSY, '0, '0, 1'b1));        // busy loading
        row(ACT_FREE,   32'h5,          32'h0, 1, 0, 1,
            outcome(KIND_ACK, STAT_BUSY, '0, '0, 1'b1));
        row(ACT_REFILL, 32'h0,          32'h3, 1, 0, 1,
            outcome(KIND_ACK, STAT_OK, '0, '0, 1'b1));          // count word
        row(ACT_REFILL, 32'hFFFF_FFFF,  32'h0, 1, 0, 0, '0);    // zero entry
        row(ACT_REFILL, 32'h0,          32'h1234, 1, 0, 0, '0);
        row(ACT_REFILL, 32'h0,          32'hFFFF_FFFF, 1, 0, 0, '0);
        row(ACT_ALLOC,  32'h0,          32'h0, 1, 0, 0, '0);
        row(ACT_ALLOC,  32'h0,          32'h0, 1, 0, 0, '0);
        row(ACT_ALLOC,  32'h0,          32'h0, 1, 0, 1,
            outcome(KIND_ACK, STAT_NO_SPACE, '0, '0, 1'b1));    // zero entry popped
        row(ACT_ALLOC,  32'h0,          32'h0, 1, 0, 1,
            outcome(KIND_ACK, STAT_NO_SPACE, '0, '0, 1'b1));    // underflow
        row(ACT_NOP,    32'hFFFF_FFFF,  32'hFFFF_FFFF, 1, 0, 0, '0);
        row(ACT_REFILL, 32'h0,          32'h0, 1, 0, 1,
            outcome(KIND_ACK, STAT_OK, '0, '0, 1'b1));          // idle count of zero
        row(ACT_REFILL, 32'h0,          32'hFFFF_FFFF, 1, 0, 1,
            outcome(KIND_ACK, STAT_BAD_NUM, '0, '0, 1'b1));     // saturated count
        row(ACT_REFILL, 32'h0,          32'h100, SLOTS, 1, 0, '0);
        row(ACT_FREE,   32'h1,          32'h0, 1, 0, 0, '0);    // spill of a full stack
        row(ACT_FREE,   32'h2,          32'h0, SLOTS - 1, 1, 0, '0);
        row(ACT_FREE,   32'hFFFF_FFFE,  32'h0, 1, 0, 0, '0);    // second spill
        row(ACT_ALLOC,  32'h0,          32'h0, 1, 0, 0, '0);    // chain pop of the spill block
        row(ACT_REFILL, 32'h0,          SLOTS + 1, 1, 0, 1,
            outcome(KIND_ACK, STAT_BAD_NUM, '0, '0, 1'b1));     // count just above size
        row(ACT_REFILL, 32'h0,          32'hDEAD_0000, SLOTS, 7, 0, '0);
        row(ACT_ALLOC,  32'h0,          32'h0, 1, 0, 0, '0);

        // single reset at the start of the run
        repeat (6) @(posedge i_clk);
        i_rst_n   <= 1'b1;
        cached_n   = '0;
        filling    = 1'b0;
        next_slot  = '0;
        vol_blocks = VOLUME_RESET;
        foreach (cached_blk[i]) cached_blk[i] = '0;

        foreach (plan[k]) begin
            w = plan[k];
            for (int j = 0; j < w.reps; j++) begin
                r.action       = w.act;
                r.block_number = w.bn + j * w.stride;
                r.refill_value = w.rv + j * w.stride;
                issue(r, w.typed, w.want);
                pace();
            end
        end

        // random phases, each under its own volume size
        vols[0] = $urandom_range(40, 2000);
        vols[1] = 32'd1;
        vols[2] = 32'hFFFF_FFFF;
        vols[3] = $urandom | 32'h1;
        foreach (vols[ph]) begin
            write_volume(vols[ph]);
            mode = $urandom_range(0, 2);
            for (int n = 0; n < 45; n++) begin
                if (burst_left == 0) mode = $urandom_range(0, 2);
                issue(random_req(mode), 1'b0, '0);
                pace();
            end
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && owed_res.size() == 0) begin
            $display("** chained_free_block_allocator: PASSED **");
        end else begin
            $display("** chained_free_block_allocator: FAILED **");
        end
        $finish;
    end

endmodule
